>>> rtl/core/tgasd_pkg.sv
// Shared types and constants for the TGA stream decoder.
// Holds the item structs, result codes, header byte offsets and phase encoding.
`default_nettype none

package tgasd_pkg;

  // One input item: a file byte plus the start-of-file marker.
  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } tgasd_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  pixel_channels;
    logic        flip_needed;
    logic [2:0]  error_code;
    logic        last;
  } tgasd_out_t;

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TYPE     = 3'd1;
  localparam logic [2:0] ERR_DEPTH    = 3'd2;
  localparam logic [2:0] ERR_SMALL    = 3'd3;
  localparam logic [2:0] ERR_OVERRUN  = 3'd4;

  // Header byte offsets.
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  // Image types, depths and other header values.
  localparam logic [7:0] TYPE_MAPPED   = 8'd1;
  localparam logic [7:0] TYPE_TRUE     = 8'd2;
  localparam logic [7:0] TYPE_GRAY     = 8'd3;
  localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
  localparam logic [7:0] DEPTH_24      = 8'd24;
  localparam logic [7:0] DEPTH_32      = 8'd32;
  localparam logic [7:0] DESC_TOP_LEFT = 8'd32;
  localparam logic [7:0] ALPHA_RESET   = 8'd255;
  localparam logic [7:0] RLE_REPEAT_BIAS = 8'd127;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_STOP   = 4'b1000
  } tgasd_phase_t;

endpackage

`default_nettype wire

>>> rtl/core/tga_stream_decoder_unit.sv
// Top level of the TGA stream decoder: input register, parser, result register.
// Depends on tgasd_pkg, tgasd_in_stage, tgasd_parser and tgasd_out_stage.
`default_nettype none

// The decoder takes one file byte per cycle and gives at most one result per
// byte: a header result on header byte 17, an error result, or one pixel result
// per pixel (a repeat packet gives a single result with its repeat count).
// A result is loaded into the result register when the parser decodes its byte
// from the input register and the result register is free or being emptied;
// the one-byte decode between the input register and the result register sets
// the rate of one byte per clock, less only while the result register is stalled.
// A byte with start_of_file set restarts parsing as header byte 0.
// alpha_fill is written through cfg_wr_en/cfg_wr_data and resets to 255.
module tga_stream_decoder_unit
  import tgasd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tgasd_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tgasd_out_t      out_data
);

  logic       item_vld;
  tgasd_in_t  item;
  logic       step;
  logic       res_vld;
  tgasd_out_t res;

  tgasd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .consume  (step),
    .item_vld (item_vld),
    .item     (item)
  );

  tgasd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (item),
    .res_vld     (res_vld),
    .res         (res)
  );

  tgasd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .res_vld   (res_vld),
    .res       (res),
    .step      (step),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/tgasd_in_stage.sv
// Input register of the TGA stream decoder.
// Holds one accepted item until the parser consumes it; uses tgasd_pkg.
`default_nettype none

module tgasd_in_stage
  import tgasd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tgasd_in_t in_data,
  input  wire logic      consume,
  output logic           item_vld,
  output tgasd_in_t      item
);

  logic      vld_r, vld_nxt;
  tgasd_in_t data_r;
  logic      take;

  // A new item can enter while the held one leaves in the same cycle.
  assign in_ready = !vld_r || consume;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (consume) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = data_r;

endmodule

`default_nettype wire

>>> rtl/core/tgasd_parser.sv
// Parse state and per-byte decode of the TGA stream decoder.
// Holds the header fields, pixel counters and color bytes; uses tgasd_pkg.
`default_nettype none

module tgasd_parser
  import tgasd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic      step,
  input  wire tgasd_in_t item,
  output logic           res_vld,
  output tgasd_out_t     res
);

  logic [7:0]   alpha_fill_r;
  tgasd_phase_t phase_r, phase_nxt, ph;
  logic [4:0]   hidx_r, hidx_nxt, hidx;
  logic [7:0]   skip_r, skip_nxt, skip;
  logic [7:0]   type_r, type_nxt, img_type;
  logic [15:0]  width_r, width_nxt, wid;
  logic [15:0]  height_r, height_nxt, hgt;
  logic [2:0]   bpp_r, bpp_nxt, bpp;
  logic [31:0]  pix_left_r, pix_left_nxt, pix_left;
  logic [7:0]   pkt_left_r, pkt_left_nxt, pkt_left;
  logic         pkt_rep_r, pkt_rep_nxt, pkt_rep;
  logic [1:0]   bip_r, bip_nxt, bip;
  logic [7:0]   color_r [3];
  logic [7:0]   color_nxt [3];

  logic [7:0]   b;
  logic         sof;
  logic         rle;
  logic [7:0]   run;
  logic [7:0]   pkt_dec;
  logic [31:0]  pix_after;
  logic [1:0]   cidx;
  logic [2:0]   bip_inc;

  assign b   = item.file_byte;
  assign sof = item.start_of_file;

  // Start of file clears the parse state before this byte is handled.
  always_comb begin
    ph       = sof ? PH_HEADER : phase_r;
    hidx     = sof ? '0 : hidx_r;
    skip     = sof ? '0 : skip_r;
    img_type = sof ? '0 : type_r;
    wid      = sof ? '0 : width_r;
    hgt      = sof ? '0 : height_r;
    bpp      = sof ? '0 : bpp_r;
    pix_left = sof ? '0 : pix_left_r;
    pkt_left = sof ? '0 : pkt_left_r;
    pkt_rep  = sof ? 1'b0 : pkt_rep_r;
    bip      = sof ? '0 : bip_r;
  end

  always_comb begin
    phase_nxt    = ph;
    hidx_nxt     = hidx;
    skip_nxt     = skip;
    type_nxt     = img_type;
    width_nxt    = wid;
    height_nxt   = hgt;
    bpp_nxt      = bpp;
    pix_left_nxt = pix_left;
    pkt_left_nxt = pkt_left;
    pkt_rep_nxt  = pkt_rep;
    bip_nxt      = bip;
    color_nxt    = color_r;
    res_vld      = 1'b0;
    res          = '0;
    rle          = (img_type == TYPE_RLE_TRUE);
    run          = 8'd1;
    pkt_dec      = pkt_left - 8'd1;
    pix_after    = pix_left;
    cidx         = (bip == 2'd3) ? 2'd0 : bip;
    bip_inc      = {1'b0, bip} + 3'd1;

    case (ph)
      PH_HEADER: begin
        hidx_nxt = hidx + 5'd1;
        case (hidx)
          HDR_ID_LEN: begin
            skip_nxt = b;
          end
          HDR_TYPE: begin
            type_nxt = b;
            if (b != TYPE_MAPPED && b != TYPE_TRUE && b != TYPE_GRAY &&
                b != TYPE_RLE_TRUE) begin
              res_vld        = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_TYPE;
              phase_nxt      = PH_STOP;
            end
          end
          HDR_WIDTH_LO:  width_nxt[7:0]   = b;
          HDR_WIDTH_HI:  width_nxt[15:8]  = b;
          HDR_HEIGHT_LO: height_nxt[7:0]  = b;
          HDR_HEIGHT_HI: height_nxt[15:8] = b;
          HDR_DEPTH: begin
            if (b != DEPTH_24 && b != DEPTH_32) begin
              res_vld        = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_DEPTH;
              phase_nxt      = PH_STOP;
            end else begin
              // Depth divided by eight: 24 gives 3, 32 gives 4.
              bpp_nxt = b[5:3];
            end
          end
          HDR_DESC: begin
            res_vld = 1'b1;
            if (wid < 16'd2 || hgt < 16'd2) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SMALL;
              phase_nxt      = PH_STOP;
            end else begin
              pix_left_nxt       = {16'd0, wid} * {16'd0, hgt};
              pkt_left_nxt       = '0;
              bip_nxt            = '0;
              phase_nxt          = (skip != 8'd0) ? PH_SKIP : PH_PIXELS;
              res.kind           = KIND_HEADER;
              res.width          = wid;
              res.height         = hgt;
              res.pixel_channels = bpp;
              res.flip_needed    = (b == DESC_TOP_LEFT);
            end
          end
          default: ;
        endcase
      end

      PH_SKIP: begin
        skip_nxt = skip - 8'd1;
        if (skip_nxt == 8'd0) begin
          phase_nxt = PH_PIXELS;
        end
      end

      PH_PIXELS: begin
        if (bpp != 3'd3 && bpp != 3'd4) begin
          phase_nxt = PH_STOP;
        end else if (rle && pkt_left == 8'd0) begin
          // Packet header byte: top bit set means one repeated pixel.
          if (!b[7]) begin
            pkt_left_nxt = b + 8'd1;
            pkt_rep_nxt  = 1'b0;
          end else begin
            pkt_left_nxt = b - RLE_REPEAT_BIAS;
            pkt_rep_nxt  = 1'b1;
          end
          bip_nxt = '0;
        end else if (bip_inc < bpp) begin
          color_nxt[cidx] = b;
          bip_nxt         = bip_inc[1:0];
        end else begin
          bip_nxt = '0;
          res_vld = 1'b1;
          if (bpp == 3'd3) begin
            color_nxt[2] = b;
            res.alpha    = alpha_fill_r;
            res.red      = b;
          end else begin
            res.alpha    = b;
            res.red      = color_r[2];
          end
          res.green = color_r[1];
          res.blue  = color_r[0];
          if (rle && pkt_rep) begin
            run = pkt_left;
            if ({24'd0, pkt_left} > pix_left) begin
              run            = pix_left[7:0];
              res.error_code = ERR_OVERRUN;
            end
            pkt_left_nxt = '0;
          end else if (rle) begin
            pkt_left_nxt = pkt_dec;
            if (pix_left == 32'd1 && pkt_dec != 8'd0) begin
              res.error_code = ERR_OVERRUN;
            end
          end
          pix_after      = pix_left - {24'd0, run};
          pix_left_nxt   = pix_after;
          res.kind       = KIND_PIXEL;
          res.repeat_res = run;
          if (pix_after == 32'd0) begin
            res.last  = 1'b1;
            phase_nxt = PH_STOP;
          end
        end
      end

      PH_STOP: ;

      default: phase_nxt = PH_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_fill_r <= ALPHA_RESET;
    end else if (cfg_wr_en) begin
      alpha_fill_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hidx_r     <= '0;
      skip_r     <= '0;
      type_r     <= '0;
      width_r    <= '0;
      height_r   <= '0;
      bpp_r      <= '0;
      pix_left_r <= '0;
      pkt_left_r <= '0;
      pkt_rep_r  <= 1'b0;
      bip_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hidx_r     <= hidx_nxt;
      skip_r     <= skip_nxt;
      type_r     <= type_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      bpp_r      <= bpp_nxt;
      pix_left_r <= pix_left_nxt;
      pkt_left_r <= pkt_left_nxt;
      pkt_rep_r  <= pkt_rep_nxt;
      bip_r      <= bip_nxt;
    end
  end

  // Color bytes are always written before they are read.
  always_ff @(posedge clk) begin
    if (step) begin
      color_r <= color_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tgasd_out_stage.sv
// Result register of the TGA stream decoder.
// Holds one result until the consumer takes it; uses tgasd_pkg.
`default_nettype none

module tgasd_out_stage
  import tgasd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_vld,
  input  wire logic       res_vld,
  input  wire tgasd_out_t res,
  output logic            step,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tgasd_out_t      out_data
);

  logic       vld_r, vld_nxt;
  tgasd_out_t data_r;
  logic       load;

  // The parser advances when an item is held and the register is free or being emptied.
  assign step = item_vld && (!vld_r || out_ready);
  assign load = step && res_vld;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire
